// ===== rtl/core/jkss_pkg.sv =====
// Shared types, character codes and register indexes for the JSON key stream splitter.
`timescale 1ns / 1ps

package jkss_pkg;

   localparam int KEY_CHARS_W = 40;
   localparam int KEY_LEN_W   = 3;
   localparam int META_CNT_W  = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [KEY_CHARS_W-1:0] KEY_CHARS_RESET     = 40'd478509561185;
   localparam logic [KEY_LEN_W-1:0]   KEY_LENGTH_RESET    = 3'd5;
   localparam logic [META_CNT_W-1:0]  META_CAPACITY_RESET = 16'd16383;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CHARS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_META_CAPACITY = 2'd2;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   typedef enum logic [4:0] {
      MODE_NORMAL = 5'b00001,
      MODE_STRING = 5'b00010,
      MODE_COLON  = 5'b00100,
      MODE_VALUE  = 5'b01000,
      MODE_AUDIO  = 5'b10000
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type          mode;
      logic                   escape;
      logic [META_CNT_W-1:0]  meta_count;
      logic                   overflow;
      logic                   started;
      logic                   fault;
   } ctrl_state_type;

   localparam ctrl_state_type CTRL_RESET = '{
      mode:       MODE_NORMAL,
      escape:     1'b0,
      meta_count: '0,
      overflow:   1'b0,
      started:    1'b0,
      fault:      1'b0
   };

   typedef struct packed {
      logic       meta_valid;
      logic [7:0] meta_byte;
      logic       audio_valid;
      logic [7:0] audio_byte;
      logic       audio_begin;
      logic       audio_end;
      logic       meta_overflow;
      logic       audio_fault;
   } result_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
   endfunction

endpackage

// ===== rtl/core/json_key_stream_splitter.sv =====
// Top level of the JSON key stream splitter: input register, scan step, result register.
`timescale 1ns / 1ps

// Takes one JSON response byte per transaction and returns one result per byte: the byte
// on the metadata side (up to meta_capacity bytes, then a sticky overflow flag), or on the
// audio side when it is content of the string value of the configured key, with begin and
// end marks on the quotes and a sticky fault flag on an escape inside that string. A
// transaction with req_tuser set restarts the parser for a new response. The block accepts
// one byte every cycle while the result register is free or rsp_tready is high; a byte passes
// an input register, the scan logic and a result register, and its result is presented on
// rsp_tdata from that result register. The rate is set by the scan step, which updates the
// whole parser state per byte. Configuration writes are always ready and take effect on the
// next cycle; write them only while no byte is in flight.
module json_key_stream_splitter #(
   parameter int KEY_MAX_CHARS = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] action (1 = restart)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] meta_valid, [8:1] meta_byte, [9] audio_valid, [17:10] audio_byte,
   // [18] audio_begin, [19] audio_end, [20] meta_overflow, [21] audio_fault, [23:22] zero
   output logic [23:0]                         rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jkss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jkss_pkg::KEY_CHARS_W-1:0]    csr_wdata
);

   localparam int TokW = 8*KEY_MAX_CHARS;
   localparam int CntW = $clog2(KEY_MAX_CHARS+2);

   logic [jkss_pkg::KEY_CHARS_W-1:0] key_chars;
   logic [jkss_pkg::KEY_LEN_W-1:0]   key_length;
   logic [jkss_pkg::META_CNT_W-1:0]  meta_capacity;

   logic       in_valid_ff, in_valid_in;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   jkss_pkg::result_type res_ff, res_in;

   jkss_pkg::ctrl_state_type st_ff, st_in;
   logic [TokW-1:0] tok_store_ff, tok_store_in;
   logic [CntW-1:0] tok_count_ff, tok_count_in;

   logic req_take;
   logic adv;

   assign csr_ready = 1'b1;

   jkss_cfg_regs u_cfg (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (csr_valid && csr_ready),
      .wr_index      (csr_index),
      .wr_data       (csr_wdata),
      .key_chars     (key_chars),
      .key_length    (key_length),
      .meta_capacity (meta_capacity)
   );

   jkss_scan #(
      .KEY_MAX_CHARS (KEY_MAX_CHARS)
   ) u_scan (
      .st             (st_ff),
      .tok_store      (tok_store_ff),
      .tok_count      (tok_count_ff),
      .key_chars      (key_chars),
      .key_length     (key_length),
      .meta_capacity  (meta_capacity),
      .action         (in_action_ff),
      .data_byte      (in_byte_ff),
      .st_next        (st_in),
      .tok_store_next (tok_store_in),
      .tok_count_next (tok_count_in),
      .res            (res_in)
   );

   // The held byte moves into the result register when that register is free or draining.
   assign adv        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= jkss_pkg::CTRL_RESET;
         tok_store_ff <= '0;
         tok_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            st_ff        <= st_in;
            tok_store_ff <= tok_store_in;
            tok_count_ff <= tok_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata;
      end
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, res_ff.audio_fault, res_ff.meta_overflow, res_ff.audio_end,
                        res_ff.audio_begin, res_ff.audio_byte, res_ff.audio_valid,
                        res_ff.meta_byte, res_ff.meta_valid};

   a_one_stream: assert property (@(posedge clock) disable iff (reset)
      adv |-> !(res_in.meta_valid && res_in.audio_valid))
      else $error("byte routed to both metadata and audio streams");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      (adv && !in_action_ff && st_ff.overflow) |=> st_ff.overflow)
      else $error("overflow flag cleared without restart");

   a_begin_from_value: assert property (@(posedge clock) disable iff (reset)
      (adv && res_in.audio_begin) |-> (st_ff.mode == jkss_pkg::MODE_VALUE && !st_ff.started))
      else $error("audio begin outside the value quote");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(st_ff))
      else $error("parser state changed without a byte");

endmodule

// ===== rtl/core/jkss_cfg_regs.sv =====
// Configuration registers: key characters, key length and metadata capacity.
`timescale 1ns / 1ps

module jkss_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [jkss_pkg::CSR_IDX_W-1:0]      wr_index,
   input  logic [jkss_pkg::KEY_CHARS_W-1:0]    wr_data,
   output logic [jkss_pkg::KEY_CHARS_W-1:0]    key_chars,
   output logic [jkss_pkg::KEY_LEN_W-1:0]      key_length,
   output logic [jkss_pkg::META_CNT_W-1:0]     meta_capacity
);

   logic [jkss_pkg::KEY_CHARS_W-1:0] key_chars_ff, key_chars_in;
   logic [jkss_pkg::KEY_LEN_W-1:0]   key_length_ff, key_length_in;
   logic [jkss_pkg::META_CNT_W-1:0]  meta_cap_ff, meta_cap_in;

   always_comb begin
      key_chars_in  = key_chars_ff;
      key_length_in = key_length_ff;
      meta_cap_in   = meta_cap_ff;
      if (wr_en) begin
         unique case (wr_index)
            jkss_pkg::CSR_KEY_CHARS:     key_chars_in = wr_data;
            jkss_pkg::CSR_KEY_LENGTH:    key_length_in = wr_data[jkss_pkg::KEY_LEN_W-1:0];
            jkss_pkg::CSR_META_CAPACITY: meta_cap_in = wr_data[jkss_pkg::META_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_chars_ff  <= jkss_pkg::KEY_CHARS_RESET;
         key_length_ff <= jkss_pkg::KEY_LENGTH_RESET;
         meta_cap_ff   <= jkss_pkg::META_CAPACITY_RESET;
      end else begin
         key_chars_ff  <= key_chars_in;
         key_length_ff <= key_length_in;
         meta_cap_ff   <= meta_cap_in;
      end
   end

   assign key_chars     = key_chars_ff;
   assign key_length    = key_length_ff;
   assign meta_capacity = meta_cap_ff;

endmodule

// ===== rtl/core/jkss_scan.sv =====
// Single-byte scan step: next parser state and the result for one input byte.
`timescale 1ns / 1ps

module jkss_scan #(
   parameter int KEY_MAX_CHARS = 5
) (
   input  jkss_pkg::ctrl_state_type                     st,
   input  logic [8*KEY_MAX_CHARS-1:0]                   tok_store,
   input  logic [$clog2(KEY_MAX_CHARS+2)-1:0]           tok_count,
   input  logic [jkss_pkg::KEY_CHARS_W-1:0]             key_chars,
   input  logic [jkss_pkg::KEY_LEN_W-1:0]               key_length,
   input  logic [jkss_pkg::META_CNT_W-1:0]              meta_capacity,
   input  logic                                         action,
   input  logic [7:0]                                   data_byte,
   output jkss_pkg::ctrl_state_type                     st_next,
   output logic [8*KEY_MAX_CHARS-1:0]                   tok_store_next,
   output logic [$clog2(KEY_MAX_CHARS+2)-1:0]           tok_count_next,
   output jkss_pkg::result_type                         res
);

   localparam int TokW = 8*KEY_MAX_CHARS;
   localparam int CntW = $clog2(KEY_MAX_CHARS+2);
   localparam int KlW  = jkss_pkg::KEY_LEN_W;
   localparam int CmpW = (CntW > KlW) ? CntW : KlW;

   logic [TokW-1:0]          key_ext;
   logic [KEY_MAX_CHARS-1:0] byte_eq;
   logic                     key_match;
   logic                     push_ok;
   logic                     push_full;

   assign key_ext = TokW'(key_chars);

   // Bytes past the key length are masked out of the compare.
   always_comb begin
      for (int i = 0; i < KEY_MAX_CHARS; i++) begin
         byte_eq[i] = (KlW'(i) >= key_length) || (tok_store[8*i +: 8] == key_ext[8*i +: 8]);
      end
      key_match = (key_length != '0) && (CmpW'(key_length) <= CmpW'(KEY_MAX_CHARS))
               && (CmpW'(tok_count) == CmpW'(key_length)) && (&byte_eq);
   end

   assign push_ok   = !st.overflow && (st.meta_count < meta_capacity);
   assign push_full = !st.overflow && !(st.meta_count < meta_capacity);

   always_comb begin
      logic mv, av, ab, ae;
      mv = 1'b0;
      av = 1'b0;
      ab = 1'b0;
      ae = 1'b0;
      st_next        = st;
      tok_store_next = tok_store;
      tok_count_next = tok_count;
      if (action) begin
         st_next        = jkss_pkg::CTRL_RESET;
         tok_store_next = '0;
         tok_count_next = '0;
      end else begin
         unique case (st.mode)
            jkss_pkg::MODE_STRING: begin
               mv = 1'b1;
               if (st.escape) begin
                  st_next.escape = 1'b0;
               end else if (data_byte == jkss_pkg::CHAR_BSLASH) begin
                  st_next.escape = 1'b1;
               end else if (data_byte == jkss_pkg::CHAR_QUOTE) begin
                  st_next.mode = key_match ? jkss_pkg::MODE_COLON : jkss_pkg::MODE_NORMAL;
               end else if (tok_count < CntW'(KEY_MAX_CHARS)) begin
                  for (int i = 0; i < KEY_MAX_CHARS; i++) begin
                     if (tok_count == CntW'(i)) begin
                        tok_store_next[8*i +: 8] = data_byte;
                     end
                  end
                  tok_count_next = tok_count + CntW'(1);
               end else begin
                  // A string longer than any key is marked so it can never match.
                  tok_count_next = CntW'(KEY_MAX_CHARS + 1);
               end
            end
            jkss_pkg::MODE_COLON: begin
               mv = 1'b1;
               if (data_byte == jkss_pkg::CHAR_COLON) begin
                  st_next.mode = jkss_pkg::MODE_VALUE;
               end else if (!jkss_pkg::is_blank(data_byte)) begin
                  st_next.mode = jkss_pkg::MODE_NORMAL;
               end
            end
            jkss_pkg::MODE_VALUE: begin
               mv = 1'b1;
               if (data_byte == jkss_pkg::CHAR_QUOTE) begin
                  if (!st.started && !st.fault) begin
                     st_next.started = 1'b1;
                     ab = 1'b1;
                  end
                  st_next.mode   = jkss_pkg::MODE_AUDIO;
                  st_next.escape = 1'b0;
               end else if (!jkss_pkg::is_blank(data_byte)) begin
                  st_next.mode = jkss_pkg::MODE_NORMAL;
               end
            end
            jkss_pkg::MODE_AUDIO: begin
               if (st.escape) begin
                  st_next.escape = 1'b0;
                  st_next.fault  = 1'b1;
               end else if (data_byte == jkss_pkg::CHAR_BSLASH) begin
                  st_next.escape = 1'b1;
               end else if (data_byte == jkss_pkg::CHAR_QUOTE) begin
                  ae = st.started;
                  mv = 1'b1;
                  st_next.mode = jkss_pkg::MODE_NORMAL;
               end else if (!st.fault && st.started) begin
                  av = 1'b1;
               end
            end
            default: begin
               st_next.mode = jkss_pkg::MODE_NORMAL;
               mv = 1'b1;
               if (data_byte == jkss_pkg::CHAR_QUOTE) begin
                  st_next.mode   = jkss_pkg::MODE_STRING;
                  st_next.escape = 1'b0;
                  tok_count_next = '0;
               end
            end
         endcase
         if (mv) begin
            if (push_ok) begin
               st_next.meta_count = st.meta_count + jkss_pkg::META_CNT_W'(1);
            end
            if (push_full) begin
               st_next.overflow = 1'b1;
            end
         end
      end
      res.meta_valid    = mv && push_ok;
      res.meta_byte     = (mv && push_ok) ? data_byte : 8'd0;
      res.audio_valid   = av;
      res.audio_byte    = av ? data_byte : 8'd0;
      res.audio_begin   = ab;
      res.audio_end     = ae;
      res.meta_overflow = st_next.overflow;
      res.audio_fault   = st_next.fault;
   end

endmodule

// ===== sim/json_key_stream_splitter_tb.sv =====
// Self-checking testbench for the JSON key stream splitter: directed table, then random JSON.
`timescale 1ns / 1ps

module json_key_stream_splitter_tb;
   import jkss_pkg::*;

   localparam int KEY_MAX_CHARS   = 5;
   localparam int DIRECTED_ROWS   = 27;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int CYCLE_LIMIT     = 400000;

   // Same bit order as rsp_tdata[21:0], lowest field declared last.
   typedef struct packed {
      logic       audio_fault;
      logic       meta_overflow;
      logic       audio_end;
      logic       audio_begin;
      logic [7:0] audio_byte;
      logic       audio_valid;
      logic [7:0] meta_byte;
      logic       meta_valid;
   } split_result_type;

   typedef struct {
      logic             restart;
      logic [7:0]       data;
      logic             typed;
      split_result_type want;
   } probe_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [KEY_CHARS_W-1:0] csr_wdata  = '0;

   // Predictor copy of the registers and the parser state.
   logic [KEY_CHARS_W-1:0]     key_chars_cfg     = KEY_CHARS_RESET;
   logic [KEY_LEN_W-1:0]       key_length_cfg    = KEY_LENGTH_RESET;
   logic [META_CNT_W-1:0]      meta_capacity_cfg = META_CAPACITY_RESET;
   scan_mode_type              parse_mode        = MODE_NORMAL;
   logic [8*KEY_MAX_CHARS-1:0] token_store       = '0;
   int unsigned                token_len         = 0;
   logic                       escape_pending    = 1'b0;
   logic [META_CNT_W-1:0]      meta_count        = '0;
   logic                       overflow_flag     = 1'b0;
   logic                       audio_started     = 1'b0;
   logic                       fault_flag        = 1'b0;

   split_result_type expected_results [$];
   int               sent_count  = 0;
   int               fail_count  = 0;
   int               cycle_count = 0;
   int               rsp_hold    = 0;
   bit               quiet_mode  = 1'b0;

   string      b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
   logic [7:0] blank_chars [4]  = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
   logic [7:0] punct_chars [10] = '{"{", "}", "[", "]", ",", CHAR_COLON,
                                    CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};

   probe_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b1, 8'hFF, 1'b1, '0},
      '{1'b0, 8'h00, 1'b1, '{meta_valid: 1'b1, meta_byte: 8'h00, default: '0}},
      '{1'b0, 8'hFF, 1'b1, '{meta_valid: 1'b1, meta_byte: 8'hFF, default: '0}},
      '{1'b0, CHAR_QUOTE,  1'b0, '0},
      '{1'b0, "a",         1'b0, '0},
      '{1'b0, "u",         1'b0, '0},
      '{1'b0, "d",         1'b0, '0},
      '{1'b0, "i",         1'b0, '0},
      '{1'b0, "o",         1'b0, '0},
      '{1'b0, CHAR_QUOTE,  1'b0, '0},
      '{1'b0, CHAR_SPACE,  1'b0, '0},
      '{1'b0, CHAR_COLON,  1'b0, '0},
      '{1'b0, CHAR_TAB,    1'b0, '0},
      '{1'b0, CHAR_CR,     1'b0, '0},
      '{1'b0, CHAR_LF,     1'b0, '0},
      '{1'b0, CHAR_QUOTE,  1'b0, '0},
      '{1'b0, "Q",         1'b0, '0},
      '{1'b0, 8'hFF,       1'b0, '0},
      '{1'b0, CHAR_BSLASH, 1'b0, '0},
      '{1'b0, "n",         1'b0, '0},
      '{1'b0, "Z",         1'b0, '0},
      '{1'b0, CHAR_QUOTE,  1'b0, '0},
      '{1'b1, 8'h00, 1'b1, '0},
      '{1'b0, CHAR_QUOTE,  1'b0, '0},
      '{1'b0, CHAR_BSLASH, 1'b0, '0},
      '{1'b0, CHAR_QUOTE,  1'b0, '0},
      '{1'b0, CHAR_QUOTE,  1'b0, '0}
   };

   json_key_stream_splitter #(
      .KEY_MAX_CHARS(KEY_MAX_CHARS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait();
      return quiet_mode ? 0 : int'($urandom_range(0, 16));
   endfunction

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
   endfunction

   function automatic logic meta_push();
      if (overflow_flag) return 1'b0;
      if (meta_count >= meta_capacity_cfg) begin
         overflow_flag = 1'b1;
         return 1'b0;
      end
      meta_count = meta_count + 1'b1;
      return 1'b1;
   endfunction

   function automatic logic key_match();
      logic [63:0] mask;
      if (key_length_cfg < 1 || key_length_cfg > KEY_MAX_CHARS) return 1'b0;
      if (token_len != key_length_cfg) return 1'b0;
      mask = (64'd1 << (8 * key_length_cfg)) - 64'd1;
      return (64'(token_store) & mask) == (64'(key_chars_cfg) & mask);
   endfunction

   // Advances the parser copy by one byte and returns the result it should give.
   function automatic split_result_type split_byte(input logic restart, input logic [7:0] b);
      split_result_type r;
      logic             kept;
      r    = '0;
      kept = 1'b0;
      if (restart) begin
         parse_mode     = MODE_NORMAL;
         token_store    = '0;
         token_len      = 0;
         escape_pending = 1'b0;
         meta_count     = '0;
         overflow_flag  = 1'b0;
         audio_started  = 1'b0;
         fault_flag     = 1'b0;
         return r;
      end
      case (parse_mode)
         MODE_STRING: begin
            kept = meta_push();
            if (escape_pending) begin
               escape_pending = 1'b0;
            end else if (b == CHAR_BSLASH) begin
               escape_pending = 1'b1;
            end else if (b == CHAR_QUOTE) begin
               parse_mode = key_match() ? MODE_COLON : MODE_NORMAL;
            end else if (token_len < KEY_MAX_CHARS) begin
               token_store[8*token_len +: 8] = b;
               token_len++;
            end else begin
               token_len = KEY_MAX_CHARS + 1;
            end
         end
         MODE_COLON: begin
            kept = meta_push();
            if (b == CHAR_COLON) parse_mode = MODE_VALUE;
            else if (!is_space(b)) parse_mode = MODE_NORMAL;
         end
         MODE_VALUE: begin
            kept = meta_push();
            if (b == CHAR_QUOTE) begin
               if (!audio_started && !fault_flag) begin
                  audio_started = 1'b1;
                  r.audio_begin = 1'b1;
               end
               parse_mode     = MODE_AUDIO;
               escape_pending = 1'b0;
            end else if (!is_space(b)) begin
               parse_mode = MODE_NORMAL;
            end
         end
         MODE_AUDIO: begin
            // Escaped characters never reach either stream and poison the audio.
            if (escape_pending) begin
               escape_pending = 1'b0;
               fault_flag     = 1'b1;
            end else if (b == CHAR_BSLASH) begin
               escape_pending = 1'b1;
            end else if (b == CHAR_QUOTE) begin
               r.audio_end = audio_started;
               kept        = meta_push();
               parse_mode  = MODE_NORMAL;
            end else if (!fault_flag && audio_started) begin
               r.audio_valid = 1'b1;
               r.audio_byte  = b;
            end
         end
         default: begin
            parse_mode = MODE_NORMAL;
            kept       = meta_push();
            if (b == CHAR_QUOTE) begin
               parse_mode     = MODE_STRING;
               token_len      = 0;
               escape_pending = 1'b0;
            end
         end
      endcase
      r.meta_valid    = kept;
      r.meta_byte     = kept ? b : 8'h00;
      r.meta_overflow = overflow_flag;
      r.audio_fault   = fault_flag;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      if (fail_count < 100)
         $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                  cycle_count, what, got, want);
      fail_count++;
   endtask

   task automatic check_result(input logic [23:0] raw, input split_result_type want);
      split_result_type got;
      got = split_result_type'(raw[21:0]);
      if (got.meta_valid !== want.meta_valid)
         report_mismatch("meta_valid", 24'(got.meta_valid), 24'(want.meta_valid));
      if (got.meta_byte !== want.meta_byte)
         report_mismatch("meta_byte", 24'(got.meta_byte), 24'(want.meta_byte));
      if (got.audio_valid !== want.audio_valid)
         report_mismatch("audio_valid", 24'(got.audio_valid), 24'(want.audio_valid));
      if (got.audio_byte !== want.audio_byte)
         report_mismatch("audio_byte", 24'(got.audio_byte), 24'(want.audio_byte));
      if (got.audio_begin !== want.audio_begin)
         report_mismatch("audio_begin", 24'(got.audio_begin), 24'(want.audio_begin));
      if (got.audio_end !== want.audio_end)
         report_mismatch("audio_end", 24'(got.audio_end), 24'(want.audio_end));
      if (got.meta_overflow !== want.meta_overflow)
         report_mismatch("meta_overflow", 24'(got.meta_overflow), 24'(want.meta_overflow));
      if (got.audio_fault !== want.audio_fault)
         report_mismatch("audio_fault", 24'(got.audio_fault), 24'(want.audio_fault));
      if (raw[23:22] !== 2'b00)
         report_mismatch("padding", 24'(raw[23:22]), 24'(2'b00));
   endtask

   task automatic send_item(input logic restart, input logic [7:0] b, input logic typed,
                            input split_result_type want);
      int               gap;
      split_result_type predicted;
      quiet_mode = ((sent_count / 150) % 4) == 3;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= restart;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predicted = split_byte(restart, b);
      expected_results.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(1'b0, b, 1'b0, '0);
   endtask

   task automatic send_blanks();
      repeat ($urandom_range(0, 2)) send_byte(blank_chars[$urandom_range(0, 3)]);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [KEY_CHARS_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY_CHARS:     key_chars_cfg     = value;
         CSR_KEY_LENGTH:    key_length_cfg    = value[KEY_LEN_W-1:0];
         CSR_META_CAPACITY: meta_capacity_cfg = value[META_CNT_W-1:0];
         default: ;
      endcase
   endtask

   // One JSON-like fragment: mostly key/value pairs, most of them aimed at the configured key.
   task automatic emit_fragment();
      int         kind;
      int         body_len;
      logic [7:0] body [8];
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         body_len = (key_length_cfg >= 1 && key_length_cfg <= KEY_MAX_CHARS) ?
                    int'(key_length_cfg) : int'($urandom_range(1, KEY_MAX_CHARS));
         for (int i = 0; i < 8; i++)
            body[i] = (i < KEY_MAX_CHARS) ? key_chars_cfg[8*i +: 8] : "x";
         case ($urandom_range(0, 9))
            0: body[$urandom_range(0, body_len - 1)] = rand_byte(8'h61, 8'h7A);
            1: if (body_len > 1) body_len--;
            2: repeat ($urandom_range(1, 3)) begin
               body[body_len] = rand_byte(8'h61, 8'h7A);
               body_len++;
            end
            default: ;
         endcase
         send_byte(CHAR_QUOTE);
         for (int i = 0; i < body_len; i++) begin
            if ($urandom_range(0, 19) == 0) send_byte(CHAR_BSLASH);
            send_byte(body[i]);
         end
         send_byte(CHAR_QUOTE);
         send_blanks();
         send_byte(($urandom_range(0, 19) == 0) ? 8'h2C : CHAR_COLON);
         send_blanks();
         send_byte(($urandom_range(0, 19) == 0) ? 8'h31 : CHAR_QUOTE);
         repeat ($urandom_range(0, 24)) begin
            if ($urandom_range(0, 49) == 0) send_byte(CHAR_BSLASH);
            send_byte(b64_chars[$urandom_range(0, b64_chars.len() - 1)]);
         end
         if ($urandom_range(0, 9) != 0) send_byte(CHAR_QUOTE);
      end else if (kind < 70) begin
         send_byte(CHAR_QUOTE);
         repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 9) == 0) begin
               send_byte(CHAR_BSLASH);
               send_byte($urandom_range(0, 9) < 5 ? CHAR_QUOTE : CHAR_BSLASH);
            end else begin
               send_byte(rand_byte(8'h61, 8'h7A));
            end
         end
         send_byte(CHAR_QUOTE);
         send_blanks();
         send_byte(CHAR_COLON);
         send_blanks();
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(rand_byte(8'h30, 8'h39));
         end else begin
            send_byte(CHAR_QUOTE);
            repeat ($urandom_range(0, 6)) send_byte(rand_byte(8'h41, 8'h5A));
            send_byte(CHAR_QUOTE);
         end
      end else if (kind < 85) begin
         repeat ($urandom_range(1, 6)) send_byte(rand_byte(0, 255));
      end else if (kind < 96) begin
         repeat ($urandom_range(1, 3)) send_byte(punct_chars[$urandom_range(0, 9)]);
      end else begin
         send_item(1'b1, rand_byte(0, 255), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_hold = draw_wait();
         if (expected_results.size() == 0)
            report_mismatch("result with nothing expected", rsp_tdata, '0);
         else
            check_result(rsp_tdata, expected_results.pop_front());
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int                     phase_end;
      logic [KEY_CHARS_W-1:0] key_value;
      logic [KEY_LEN_W-1:0]   len_value;
      logic [META_CNT_W-1:0]  cap_value;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part runs on the register values left by reset.
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_item(directed_rows[r].restart, directed_rows[r].data,
                   directed_rows[r].typed, directed_rows[r].want);

      for (int p = 0; p < PHASES; p++) begin
         key_value = KEY_CHARS_RESET;
         len_value = KEY_LENGTH_RESET;
         cap_value = META_CAPACITY_RESET;
         case (p)
            0: cap_value = 16'd40;
            1: begin
               for (int i = 0; i < KEY_MAX_CHARS; i++)
                  key_value[8*i +: 8] = rand_byte(8'h61, 8'h7A);
               len_value = KEY_LEN_W'($urandom_range(1, KEY_MAX_CHARS));
               cap_value = 16'hFFFF;
            end
            2: begin
               key_value = '0;
               len_value = KEY_LEN_W'($urandom_range(1, KEY_MAX_CHARS));
               cap_value = 16'd1;
            end
            3: begin
               key_value = '1;
               cap_value = 16'hFFFF;
            end
            4: begin
               key_value = KEY_CHARS_W'({$urandom(), $urandom()});
               len_value = 3'd0;
               cap_value = META_CNT_W'($urandom_range(1, 300));
            end
            5: len_value = 3'd7;
            6: begin
               key_value = 40'h6261;
               len_value = 3'd2;
               cap_value = 16'd0;
            end
            7: begin
               len_value = 3'd3;
               cap_value = 16'hFFFF;
            end
            default: begin
               for (int i = 0; i < KEY_MAX_CHARS; i++)
                  key_value[8*i +: 8] = rand_byte(8'h61, 8'h7A);
               len_value = 3'd1;
               cap_value = META_CNT_W'($urandom_range(50, 500));
            end
         endcase

         // Registers change only once every byte in flight has come out.
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (expected_results.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         write_csr(CSR_KEY_CHARS, key_value);
         write_csr(CSR_KEY_LENGTH, KEY_CHARS_W'(len_value));
         write_csr(CSR_META_CAPACITY, KEY_CHARS_W'(cap_value));
         @(negedge clock);
         csr_valid <= 1'b0;

         phase_end = sent_count + ITEMS_PER_PHASE;
         while (sent_count < phase_end) emit_fragment();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
